FILE: hw/rtl/lcar_pkg.sv
package lcar_pkg;

    localparam int ADC_BITS    = 24;
    localparam int MAX_AVERAGE = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HALF_W     = 16;
    localparam int DIV_W      = 16;
    localparam int SAMP_W     = 5;

    localparam int SUM_W  = 28;
    localparam int DIFF_W = SUM_W + 1;
    localparam int DEN_W  = 20;
    localparam int DVD_W  = 35;
    localparam int STEP_W = 6;
    localparam int OUT_W  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES       = 2'd2;

    localparam logic [HALF_W-1:0] HALF_RESET    = 16'd2;
    localparam logic [DIV_W-1:0]  DIVISOR_RESET = 16'd495;
    localparam logic [SAMP_W-1:0] SAMPLES_RESET = 5'd2;

    localparam logic [ADC_BITS-1:0] TOP_BIT = 24'h800000;

    localparam logic [30:0] WEIGHT_LIMIT = 31'd1677721500;

    typedef struct packed {
        logic                     sck;
        logic                     meas;
        logic                     tare;
        logic signed [DIFF_W-1:0] diff;
        logic [DEN_W-1:0]         denom;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: hw/rtl/lcar_if.sv
interface lcar_in_if;
    logic valid;
    logic ready;
    logic dout_level;

    modport source (output valid, output dout_level, input ready);
    modport sink (input valid, input dout_level, output ready);
endinterface

interface lcar_out_if;
    logic              valid;
    logic              ready;
    logic              sck_level;
    logic              result_valid;
    logic              tare_captured;
    logic signed [31:0] weight_centi;
    logic              above_zero;

    modport source (output valid, output sck_level, output result_valid,
                    output tare_captured, output weight_centi, output above_zero,
                    input ready);
    modport sink (input valid, input sck_level, input result_valid,
                  input tare_captured, input weight_centi, input above_zero,
                  output ready);
endinterface

FILE: hw/rtl/lcar_front.sv
module lcar_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lcar_in_if.sink                            i_in,
    input  logic                               i_cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  lcar_pkg::t_q_stat                  i_q_stat,
    output logic                               o_push,
    output lcar_pkg::t_job                     o_job
);

    typedef enum logic [2:0] {
        PH_SETTLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_XHIGH,
        PH_XLOW
    } t_phase;

    logic [lcar_pkg::HALF_W-1:0]   r_half;
    logic [lcar_pkg::DIV_W-1:0]    r_div;
    logic [lcar_pkg::SAMP_W-1:0]   r_samp;

    t_phase                         r_phase,  n_phase;
    logic [lcar_pkg::HALF_W-1:0]   r_delay,  n_delay;
    logic [4:0]                    r_bits,   n_bits;
    logic [lcar_pkg::ADC_BITS-1:0] r_shift,  n_shift;
    logic [4:0]                    r_rcnt,   n_rcnt;
    logic [lcar_pkg::SUM_W-1:0]    r_sum,    n_sum;
    logic [lcar_pkg::SUM_W-1:0]    r_tare,   n_tare;
    logic                          r_tare_ok, n_tare_ok;

    logic                          accept;
    logic [lcar_pkg::HALF_W-1:0]   len;
    logic [lcar_pkg::HALF_W-1:0]   dinc;
    logic                          tdone;
    logic [lcar_pkg::HALF_W-1:0]   delay_timed;
    logic [lcar_pkg::DIV_W-1:0]    div_eff;
    logic [lcar_pkg::SAMP_W-1:0]   cnt_eff;
    logic [lcar_pkg::ADC_BITS-1:0] reading;
    logic [lcar_pkg::SUM_W-1:0]    sum_add;
    logic [4:0]                    rcnt_inc;
    logic [4:0]                    bits_inc;
    logic [lcar_pkg::DEN_W:0]      prod;
    logic signed [lcar_pkg::DIFF_W-1:0] diff;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept;

    always_comb begin
        len         = (r_half == '0) ? lcar_pkg::HALF_W'(1) : r_half;
        dinc        = r_delay + lcar_pkg::HALF_W'(1);
        tdone       = (dinc >= len) || (dinc == '0);
        delay_timed = tdone ? '0 : dinc;

        div_eff = (r_div == '0) ? lcar_pkg::DIV_W'(1) : r_div;
        if (r_samp == '0) begin
            cnt_eff = lcar_pkg::SAMP_W'(1);
        end else if (r_samp > lcar_pkg::SAMP_W'(lcar_pkg::MAX_AVERAGE)) begin
            cnt_eff = lcar_pkg::SAMP_W'(lcar_pkg::MAX_AVERAGE);
        end else begin
            cnt_eff = r_samp;
        end

        // offset binary: flip the sign bit of the two's complement reading
        reading  = r_shift ^ lcar_pkg::TOP_BIT;
        sum_add  = r_sum + lcar_pkg::SUM_W'(reading);
        rcnt_inc = r_rcnt + 5'd1;
        bits_inc = r_bits + 5'd1;
        diff     = $signed({1'b0, sum_add}) - $signed({1'b0, r_tare});
        prod     = {5'b0, div_eff} * {16'b0, cnt_eff};

        n_phase   = r_phase;
        n_delay   = r_delay;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_rcnt    = r_rcnt;
        n_sum     = r_sum;
        n_tare    = r_tare;
        n_tare_ok = r_tare_ok;

        o_job       = '0;
        o_job.diff  = diff;
        o_job.denom = prod[lcar_pkg::DEN_W-1:0];

        unique case (r_phase)
            PH_SETTLE: begin
                n_delay = delay_timed;
                if (tdone) begin
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                n_delay = '0;
                if (!i_in.dout_level) begin
                    n_phase = PH_HIGH;
                    n_bits  = '0;
                    n_shift = '0;
                end
            end
            PH_HIGH: begin
                o_job.sck = 1'b1;
                n_delay   = delay_timed;
                if (tdone) begin
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_delay = delay_timed;
                if (tdone) begin
                    n_shift = {r_shift[lcar_pkg::ADC_BITS-2:0], i_in.dout_level};
                    n_bits  = bits_inc;
                    n_phase = (bits_inc >= 5'(lcar_pkg::ADC_BITS)) ? PH_XHIGH : PH_HIGH;
                end
            end
            PH_XHIGH: begin
                o_job.sck = 1'b1;
                n_delay   = delay_timed;
                if (tdone) begin
                    n_phase = PH_XLOW;
                end
            end
            PH_XLOW: begin
                n_delay = delay_timed;
                if (tdone) begin
                    n_sum   = sum_add;
                    n_rcnt  = rcnt_inc;
                    n_phase = PH_SETTLE;
                    n_bits  = '0;
                    if (rcnt_inc >= cnt_eff) begin
                        o_job.meas = 1'b1;
                        if (!r_tare_ok) begin
                            n_tare     = sum_add;
                            n_tare_ok  = 1'b1;
                            o_job.tare = 1'b1;
                        end
                        n_sum  = '0;
                        n_rcnt = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_SETTLE;
                n_delay = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= lcar_pkg::HALF_RESET;
            r_div     <= lcar_pkg::DIVISOR_RESET;
            r_samp    <= lcar_pkg::SAMPLES_RESET;
            r_phase   <= PH_SETTLE;
            r_delay   <= '0;
            r_bits    <= '0;
            r_shift   <= '0;
            r_rcnt    <= '0;
            r_sum     <= '0;
            r_tare    <= '0;
            r_tare_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lcar_pkg::CFG_HALF_PERIOD:   r_half <= i_cfg_data;
                    lcar_pkg::CFG_SCALE_DIVISOR: r_div  <= i_cfg_data;
                    lcar_pkg::CFG_SAMPLES:       r_samp <= i_cfg_data[lcar_pkg::SAMP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_delay   <= n_delay;
                r_bits    <= n_bits;
                r_shift   <= n_shift;
                r_rcnt    <= n_rcnt;
                r_sum     <= n_sum;
                r_tare    <= n_tare;
                r_tare_ok <= n_tare_ok;
            end
        end
    end

endmodule

FILE: hw/rtl/lcar_queue.sv
module lcar_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcar_pkg::t_job     i_job,
    input  logic               i_pop,
    output lcar_pkg::t_job     o_job,
    output lcar_pkg::t_q_stat  o_stat
);

    lcar_pkg::t_job                r_mem [lcar_pkg::QUEUE_DEPTH];
    logic [lcar_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [lcar_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [lcar_pkg::QCNT_W-1:0]   r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == lcar_pkg::QCNT_W'(lcar_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + lcar_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + lcar_pkg::QPTR_W'(1);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + lcar_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - lcar_pkg::QCNT_W'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

endmodule

FILE: hw/rtl/lcar_back.sv
module lcar_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcar_pkg::t_job     i_job,
    input  lcar_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    lcar_out_if.source         o_out
);

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_MUL,
        BS_DIV,
        BS_DONE
    } t_bstate;

    t_bstate                          r_state;
    logic [lcar_pkg::STEP_W-1:0]      r_step;
    logic                             r_neg;
    logic [lcar_pkg::SUM_W-1:0]       r_mag;
    logic [lcar_pkg::DEN_W-1:0]       r_den;
    logic [lcar_pkg::DEN_W-1:0]       r_rem;
    logic [lcar_pkg::DVD_W-1:0]       r_quo;
    logic                             r_sck;

    logic                             r_ov;
    logic                             r_o_sck;
    logic                             r_o_meas;
    logic                             r_o_tare;
    logic signed [lcar_pkg::OUT_W-1:0] r_o_weight;
    logic                             r_o_above;

    logic                             out_free;
    logic                             out_load;
    logic                             is_div;
    logic [lcar_pkg::DIFF_W-1:0]      dabs;
    logic [lcar_pkg::DVD_W-1:0]       mag_w;
    logic [lcar_pkg::DVD_W-1:0]       dvd;
    logic [lcar_pkg::DEN_W:0]         trial;
    logic                             fits;
    logic [30:0]                      q_sat;
    logic signed [lcar_pkg::OUT_W-1:0] w_pos;
    logic signed [lcar_pkg::OUT_W-1:0] w_fin;

    assign out_free = !r_ov || o_out.ready;
    assign is_div   = i_job.meas && !i_job.tare;
    // divide words leave at once; the rest need the output register
    assign o_pop    = (r_state == BS_IDLE) && !i_q_stat.empty && (is_div || out_free);
    assign out_load = ((r_state == BS_IDLE) && o_pop && !is_div) ||
                      ((r_state == BS_DONE) && out_free);

    assign o_out.valid         = r_ov;
    assign o_out.sck_level     = r_o_sck;
    assign o_out.result_valid  = r_o_meas;
    assign o_out.tare_captured = r_o_tare;
    assign o_out.weight_centi  = r_o_weight;
    assign o_out.above_zero    = r_o_above;

    always_comb begin
        dabs  = i_job.diff[lcar_pkg::DIFF_W-1] ? lcar_pkg::DIFF_W'(-i_job.diff)
                                               : lcar_pkg::DIFF_W'(i_job.diff);
        // times 100 as 64 + 32 + 4
        mag_w = lcar_pkg::DVD_W'(r_mag);
        dvd   = (mag_w << 6) + (mag_w << 5) + (mag_w << 2);
        trial = {r_rem, r_quo[lcar_pkg::DVD_W-1]};
        fits  = (trial >= {1'b0, r_den});
        q_sat = (r_quo > lcar_pkg::DVD_W'(lcar_pkg::WEIGHT_LIMIT)) ? lcar_pkg::WEIGHT_LIMIT
                                                                  : r_quo[30:0];
        w_pos = $signed({1'b0, q_sat});
        w_fin = r_neg ? -w_pos : w_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_step  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // hold the word until taken, load a new one when the register frees
            r_ov <= out_load || (r_ov && !o_out.ready);
            unique case (r_state)
                BS_IDLE: begin
                    if (o_pop) begin
                        if (is_div) begin
                            r_neg   <= i_job.diff[lcar_pkg::DIFF_W-1];
                            r_mag   <= dabs[lcar_pkg::SUM_W-1:0];
                            r_den   <= i_job.denom;
                            r_sck   <= i_job.sck;
                            r_state <= BS_MUL;
                        end else begin
                            r_o_sck    <= i_job.sck;
                            r_o_meas   <= i_job.meas;
                            r_o_tare   <= i_job.tare;
                            r_o_weight <= '0;
                            r_o_above  <= 1'b0;
                        end
                    end
                end
                BS_MUL: begin
                    r_quo   <= dvd;
                    r_rem   <= '0;
                    r_step  <= lcar_pkg::STEP_W'(lcar_pkg::DVD_W - 1);
                    r_state <= BS_DIV;
                end
                BS_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= fits ? lcar_pkg::DEN_W'(trial - {1'b0, r_den})
                                  : trial[lcar_pkg::DEN_W-1:0];
                    r_quo <= {r_quo[lcar_pkg::DVD_W-2:0], fits};
                    r_step <= r_step - lcar_pkg::STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= BS_DONE;
                    end
                end
                BS_DONE: begin
                    if (out_free) begin
                        r_o_sck    <= r_sck;
                        r_o_meas   <= 1'b1;
                        r_o_tare   <= 1'b0;
                        r_o_weight <= w_fin;
                        r_o_above  <= !r_neg && (q_sat != '0);
                        r_state    <= BS_IDLE;
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/load_cell_adc_reader_core.sv
// Reader for a 24-bit two-wire load cell converter. Each input word is one tick of the
// data pin; each tick yields exactly one output word with the clock pin level for that
// tick and, on the tick a measurement completes, the tare flag or the weight in hundredths
// (offset-binary readings summed over samples_per_average, minus the first such sum taken
// after reset, times 100, over scale_divisor times the count). Configuration is taken on
// the write port whenever i_cfg_we is high. A plain tick passes through the queue and then
// the output register, and input and output run at one word per cycle while no weight
// word holds the back unit and the output is not stalled. A weight word goes through the
// back unit in order: forming the dividend, a bit-serial restoring divider at one quotient
// bit per cycle over 35 bits, and loading the output; a 4-word queue keeps accepting ticks
// meanwhile, and once it is full, ready drops until the weight word has left the back unit.
module load_cell_adc_reader_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lcar_in_if.sink                         i_in,
    lcar_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcar_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               push;
    logic               pop;
    lcar_pkg::t_job     job_in;
    lcar_pkg::t_job     job_out;
    lcar_pkg::t_q_stat  q_stat;

    lcar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job_in)
    );

    lcar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    lcar_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_out),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

FILE: hw/rtl/lcar_checker.sv
module lcar_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic        i_result_valid,
    input  logic        i_tare_captured,
    input  logic signed [31:0] i_weight_centi,
    input  logic        i_above_zero
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output word dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_weight_centi) && $stable(i_result_valid))
        else $error("output word changed while stalled");

    a_tare_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_tare_captured |->
            i_result_valid && (i_weight_centi == 32'sd0) && !i_above_zero)
        else $error("tare word carries a weight");

    a_idle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_result_valid |->
            (i_weight_centi == 32'sd0) && !i_above_zero && !i_tare_captured)
        else $error("tick word without measurement carries data");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_result_valid && !i_tare_captured |->
            (i_above_zero == (i_weight_centi > 32'sd0)) &&
            (i_weight_centi <= $signed({1'b0, lcar_pkg::WEIGHT_LIMIT})) &&
            (i_weight_centi >= -$signed({1'b0, lcar_pkg::WEIGHT_LIMIT})))
        else $error("weight out of range or sign flag wrong");

endmodule

bind load_cell_adc_reader_core lcar_checker u_lcar_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_out.valid),
    .i_ready         (o_out.ready),
    .i_result_valid  (o_out.result_valid),
    .i_tare_captured (o_out.tare_captured),
    .i_weight_centi  (o_out.weight_centi),
    .i_above_zero    (o_out.above_zero)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 45;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_SOME  = 1;
    localparam int IDLE_HEAVY = 2;

    localparam logic [lcar_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [2:0] PH_SETTLE = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd1;
    localparam logic [2:0] PH_HIGH   = 3'd2;
    localparam logic [2:0] PH_LOW    = 3'd3;
    localparam logic [2:0] PH_XHIGH  = 3'd4;
    localparam logic [2:0] PH_XLOW   = 3'd5;

    typedef struct packed {
        logic [2:0]                    ph;
        logic [15:0]                   dly;
        logic [4:0]                    nbits;
        logic [lcar_pkg::ADC_BITS-1:0] shreg;
        logic [4:0]                    nread;
        logic [lcar_pkg::SUM_W-1:0]    acc;
        logic [lcar_pkg::SUM_W-1:0]    tare;
        logic                          tare_ok;
    } t_rdr;

    typedef struct packed {
        logic               sck;
        logic               meas;
        logic               tare;
        logic signed [31:0] wt;
        logic               pos;
    } t_tick_out;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            cfg_we;
    logic [lcar_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [lcar_pkg::CFG_DATA_W-1:0] cfg_data;

    lcar_in_if  tick_if ();
    lcar_out_if res_if ();

    load_cell_adc_reader_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copies as the block holds them
    logic [lcar_pkg::HALF_W-1:0] reg_half;
    logic [lcar_pkg::DIV_W-1:0]  reg_div;
    logic [lcar_pkg::SAMP_W-1:0] reg_samp;

    t_rdr pred_rdr = '0;
    t_rdr stim_rdr;

    logic        dout_q[$];
    t_tick_out   tick_results_q[$];

    int in_mode;
    int out_mode;
    int wait_span;
    logic                          use_fixed;
    logic [lcar_pkg::ADC_BITS-1:0] fixed_offset;
    logic [lcar_pkg::ADC_BITS-1:0] stim_raw;

    int tick_gap;
    int rdy_hold;
    int quiet_cycles = 0;
    int n_ticks      = 0;
    int n_meas       = 0;
    int n_pos        = 0;
    int n_sat        = 0;
    int n_errors     = 0;

    function automatic logic half_end(input logic [15:0] dly, input logic [15:0] len);
        logic [15:0] nxt;
        nxt = dly + 16'd1;
        return (nxt >= len) || (nxt == 16'd0);
    endfunction

    // one pin tick through the reader: next state and the output word
    function automatic void advance_reader(input t_rdr cur, input logic dout,
                                           output t_rdr nxt, output t_tick_out res);
        logic [15:0] len;
        logic        fin;
        logic [4:0]  cnt;
        longint      divisor;
        longint      diff;
        longint      wt;
        nxt = cur;
        res = '0;
        len = (reg_half == '0) ? 16'd1 : reg_half;
        fin = half_end(cur.dly, len);
        divisor = (reg_div == '0) ? 64'sd1 : longint'(reg_div);
        if (reg_samp == '0) cnt = 5'd1;
        else if (reg_samp > lcar_pkg::MAX_AVERAGE) cnt = 5'(lcar_pkg::MAX_AVERAGE);
        else cnt = reg_samp;
        nxt.dly = fin ? 16'd0 : cur.dly + 16'd1;
        case (cur.ph)
            PH_SETTLE: begin
                if (fin) nxt.ph = PH_WAIT;
            end
            PH_WAIT: begin
                nxt.dly = '0;
                if (!dout) begin
                    nxt.ph    = PH_HIGH;
                    nxt.nbits = '0;
                    nxt.shreg = '0;
                end
            end
            PH_HIGH, PH_XHIGH: begin
                res.sck = 1'b1;
                if (fin) nxt.ph = (cur.ph == PH_HIGH) ? PH_LOW : PH_XLOW;
            end
            PH_LOW: begin
                if (fin) begin
                    nxt.shreg = {cur.shreg[lcar_pkg::ADC_BITS-2:0], dout};
                    nxt.nbits = cur.nbits + 5'd1;
                    nxt.ph    = (nxt.nbits >= lcar_pkg::ADC_BITS) ? PH_XHIGH : PH_HIGH;
                end
            end
            PH_XLOW: begin
                if (fin) begin
                    nxt.acc   = cur.acc + {{(lcar_pkg::SUM_W-lcar_pkg::ADC_BITS){1'b0}},
                                           cur.shreg ^ lcar_pkg::TOP_BIT};
                    nxt.nread = cur.nread + 5'd1;
                    nxt.ph    = PH_SETTLE;
                    nxt.nbits = '0;
                    if (nxt.nread >= cnt) begin
                        res.meas = 1'b1;
                        if (!cur.tare_ok) begin
                            nxt.tare    = nxt.acc;
                            nxt.tare_ok = 1'b1;
                            res.tare    = 1'b1;
                        end else begin
                            diff = longint'(nxt.acc) - longint'(cur.tare);
                            wt   = (diff * 64'sd100) / (divisor * longint'(cnt));
                            if (wt > longint'(lcar_pkg::WEIGHT_LIMIT))
                                wt = longint'(lcar_pkg::WEIGHT_LIMIT);
                            if (wt < -longint'(lcar_pkg::WEIGHT_LIMIT))
                                wt = -longint'(lcar_pkg::WEIGHT_LIMIT);
                            res.wt  = wt[31:0];
                            res.pos = (wt > 0);
                        end
                        nxt.acc   = '0;
                        nxt.nread = '0;
                    end
                end
            end
            default: begin
                nxt.ph  = PH_SETTLE;
                nxt.dly = '0;
            end
        endcase
    endfunction

    function automatic int draw_wait(input int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(4) == 0) ? $urandom_range(13) : 0;
            default:   return $urandom_range(13);
        endcase
    endfunction

    function automatic logic [lcar_pkg::ADC_BITS-1:0] pick_offset();
        logic [31:0] rnd;
        rnd = $urandom;
        if (use_fixed) return fixed_offset;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return lcar_pkg::TOP_BIT;
            default: return rnd[lcar_pkg::ADC_BITS-1:0];
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH word %0d %s: got %0d, expected %0d", n_ticks, what, got, want);
        n_errors++;
    endtask

    // queue one pin level, shaped so the reader sees the chosen reading
    task automatic make_tick(output logic meas, output logic rd_end);
        logic        dout;
        logic [2:0]  ph0;
        logic [15:0] len;
        t_tick_out   r;
        len = (reg_half == '0) ? 16'd1 : reg_half;
        ph0 = stim_rdr.ph;
        case (stim_rdr.ph)
            PH_WAIT: begin
                dout = ($urandom_range(wait_span) != 0);
                if (!dout) stim_raw = pick_offset() ^ lcar_pkg::TOP_BIT;
            end
            PH_LOW: begin
                if (half_end(stim_rdr.dly, len))
                    dout = stim_raw[lcar_pkg::ADC_BITS-1-stim_rdr.nbits];
                else
                    dout = ($urandom_range(1) == 1);
            end
            default: dout = ($urandom_range(1) == 1);
        endcase
        advance_reader(stim_rdr, dout, stim_rdr, r);
        meas   = r.meas;
        rd_end = (ph0 == PH_XLOW) && (stim_rdr.ph == PH_SETTLE);
        dout_q.push_back(dout);
    endtask

    task automatic send_ticks(input int n);
        logic meas;
        logic rd_end;
        repeat (n) make_tick(meas, rd_end);
    endtask

    // stop after n completed measurements, or n readings when by_meas is low
    task automatic send_readings(input int n, input logic by_meas);
        logic meas;
        logic rd_end;
        int   done;
        done = 0;
        while (done < n) begin
            make_tick(meas, rd_end);
            if (by_meas ? meas : rd_end) done++;
        end
    endtask

    task automatic settle_idle();
        while (dout_q.size() != 0 || tick_if.valid || tick_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lcar_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcar_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            lcar_pkg::CFG_HALF_PERIOD:   reg_half = data;
            lcar_pkg::CFG_SCALE_DIVISOR: reg_div  = data;
            lcar_pkg::CFG_SAMPLES:       reg_samp = data[lcar_pkg::SAMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] half, input logic [15:0] div,
                            input logic [15:0] samp);
        write_reg(lcar_pkg::CFG_HALF_PERIOD, half);
        write_reg(lcar_pkg::CFG_SCALE_DIVISOR, div);
        write_reg(lcar_pkg::CFG_SAMPLES, samp);
    endtask

    // driver: one pin level per word, random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid      <= 1'b0;
            tick_if.dout_level <= 1'b0;
            tick_gap           <= 0;
        end else if (!tick_if.valid || tick_if.ready) begin
            if (tick_gap != 0) begin
                tick_if.valid <= 1'b0;
                tick_gap      <= tick_gap - 1;
            end else if (dout_q.size() != 0) begin
                tick_if.valid      <= 1'b1;
                tick_if.dout_level <= dout_q.pop_front();
                tick_gap           <= draw_wait(in_mode);
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted ticks, check result words, stall the result side
    always @(posedge i_clk) begin : res_mon
        t_tick_out want;
        t_tick_out nxt_out;
        int        w;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rdy_hold     <= 0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                advance_reader(pred_rdr, tick_if.dout_level, pred_rdr, nxt_out);
                tick_results_q.push_back(nxt_out);
            end
            if (res_if.valid && res_if.ready) begin
                if (tick_results_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = tick_results_q.pop_front();
                    if (res_if.sck_level !== want.sck)
                        report_mismatch("sck_level", res_if.sck_level, want.sck);
                    if (res_if.result_valid !== want.meas)
                        report_mismatch("result_valid", res_if.result_valid, want.meas);
                    if (res_if.tare_captured !== want.tare)
                        report_mismatch("tare_captured", res_if.tare_captured, want.tare);
                    if (res_if.weight_centi !== want.wt)
                        report_mismatch("weight_centi", res_if.weight_centi, want.wt);
                    if (res_if.above_zero !== want.pos)
                        report_mismatch("above_zero", res_if.above_zero, want.pos);
                    n_ticks++;
                    if (want.meas) n_meas++;
                    if (want.pos) n_pos++;
                    if (want.meas &&
                        (want.wt == $signed({1'b0, lcar_pkg::WEIGHT_LIMIT}) ||
                         want.wt == -$signed({1'b0, lcar_pkg::WEIGHT_LIMIT})))
                        n_sat++;
                end
                w = draw_wait(out_mode);
                res_if.ready <= (w == 0);
                rdy_hold     <= w;
            end else if (rdy_hold != 0) begin
                res_if.ready <= (rdy_hold == 1);
                rdy_hold     <= rdy_hold - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, tick_results_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        reg_half           = lcar_pkg::HALF_RESET;
        reg_div            = lcar_pkg::DIVISOR_RESET;
        reg_samp           = lcar_pkg::SAMPLES_RESET;
        stim_rdr           = '0;
        stim_raw           = '0;
        in_mode            = IDLE_NONE;
        out_mode           = IDLE_NONE;
        wait_span          = 2;
        use_fixed          = 1'b1;
        fixed_offset       = 24'h900000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tare at reset settings, just above one full-scale reading
        send_readings(1, 1'b1);
        settle_idle();

        // fastest clocking, divisor one: empty reading drives the weight to the low limit
        set_regs(16'd1, 16'd1, 16'd1);
        fixed_offset = '0;
        send_readings(1, 1'b1);
        fixed_offset = '1;
        send_readings(1, 1'b1);
        settle_idle();

        // pile up full-scale readings under a long average, then cut the average short
        write_reg(lcar_pkg::CFG_SAMPLES, 16'd16);
        send_readings(2, 1'b0);
        settle_idle();
        write_reg(lcar_pkg::CFG_SAMPLES, 16'd1);
        send_readings(1, 1'b1);
        settle_idle();

        // zero registers fall back to one
        use_fixed = 1'b0;
        in_mode   = IDLE_SOME;
        out_mode  = IDLE_SOME;
        set_regs(16'd0, 16'd0, 16'd0);
        send_readings(1, 1'b1);
        settle_idle();

        // longest half period, then shorten it while the settle count is past the new end
        in_mode  = IDLE_HEAVY;
        out_mode = IDLE_HEAVY;
        write_reg(lcar_pkg::CFG_HALF_PERIOD, 16'hFFFF);
        send_ticks(30);
        settle_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_regs(16'd1, 16'hFFFF, 16'd1);
        wait_span = 6;
        send_readings(2, 1'b1);
        settle_idle();

        $display("checked %0d pin ticks and %0d measurements: %0d above zero, %0d at the limit",
                 n_ticks, n_meas, n_pos, n_sat);
        $display("%0d mismatching fields", n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
